@@ sv/zsaf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and byte helpers for the ZIP store framer.
package zsaf_pkg;

	typedef enum logic [2:0] {
		CMD_BEGIN = 3'd0,
		CMD_NAME  = 3'd1,
		CMD_DATA  = 3'd2,
		CMD_END   = 3'd3,
		CMD_PULL  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_NAME  = 3'd2,
		ST_ORDER = 3'd3,
		ST_DONE  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_NAMES = 3'd1,
		PH_DATA  = 3'd2,
		PH_TRAIL = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		JK_SINGLE = 2'd0,
		JK_LHDR   = 2'd1,
		JK_DESC   = 2'd2,
		JK_PULL   = 2'd3
	} job_kind_t;

	localparam logic [31:0] SIG_LOCAL   = 32'h04034b50;
	localparam logic [31:0] SIG_DESC    = 32'h08074b50;
	localparam logic [31:0] SIG_CENTRAL = 32'h02014b50;
	localparam logic [31:0] SIG_EOCD    = 32'h06054b50;
	localparam logic [15:0] GP_FLAG     = 16'h0808;
	localparam logic [15:0] VERSION     = 16'd20;
	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;

	localparam int POSW = 8;	// trailer record position, below 46 + 127
	localparam logic [POSW-1:0] CEN_FIXED = 8'd46;
	localparam logic [POSW-1:0] EOCD_LEN  = 8'd22;
	localparam logic [4:0] LHDR_LAST = 5'd29;
	localparam logic [4:0] DESC_LAST = 5'd15;

	function automatic logic [7:0] byte_of(input logic [31:0] v, input logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = v[7:0];
			2'd1: r = v[15:8];
			2'd2: r = v[23:16];
			default: r = v[31:24];
		endcase
		return r;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ sv/zsaf_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module zsaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ sv/zip_store_archive_framer_core.sv @@
`timescale 1ns / 1ps
// Top level of the streaming ZIP (STORE, data descriptor) archive framer.
//
// Each accepted request is one command: begin (30-byte local header), name
// byte, data byte (echoed, folded into CRC-32 and size), end (16-byte data
// descriptor) or pull (one byte of central directory / EOCD). Name, data and
// error requests stream back to back, and begin and end send one output byte
// per cycle from the job register, while out_stall is low. A pull holds off
// the next request until its byte is emitted: the entry tables and name store
// are synchronous RAMs, and the pull's position update waits on the read data.
// Output is held in a register so the next request is taken while a byte waits
// on out_stall. Errors leave the state untouched and return a single zero byte
// with last set and the error status; after the final EOCD byte every request
// returns the archive-done status. Entry tables are not cleared at reset and
// are only read for entries already closed.
module zip_store_archive_framer_core #(
	parameter int MAX_ENTRIES = 64,
	parameter int MAX_NAME = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  in_byte,
	input  logic [6:0]  name_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        end_of_archive,
	output logic [2:0]  status
);
	import zsaf_pkg::*;

	localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int ND  = MAX_ENTRIES * MAX_NAME;
	localparam int NAW = (ND > 1) ? $clog2(ND) : 1;
	localparam logic [CW-1:0] MAX_ENT_C = CW'(MAX_ENTRIES);
	localparam logic [6:0]    MAX_NAME_C = 7'((MAX_NAME > 127) ? 127 : MAX_NAME);

	// architectural state
	phase_t          phase_q;
	logic [CW-1:0]   entry_count_q;
	logic [31:0]     crc_q;
	logic [31:0]     data_count_q;
	logic [31:0]     bytes_written_q;
	logic [31:0]     dir_offset_q;
	logic [6:0]      name_rem_q;
	logic [6:0]      name_pos_q;
	logic [CW-1:0]   trail_entry_q;
	logic [POSW-1:0] trail_pos_q;

	// job register: one request being turned into output bytes
	logic            job_v_q;
	job_kind_t       job_kind_q;
	logic [4:0]      job_idx_q;
	logic [7:0]      job_byte_q;
	status_t         job_st_q;
	logic [6:0]      job_nl_q;
	logic [31:0]     job_crc_q;
	logic [31:0]     job_size_q;
	logic [31:0]     job_dir_q;
	logic [CW-1:0]   job_cnt_q;
	logic [POSW-1:0] job_pos_q;
	logic            job_eocd_q;

	// output register
	logic            out_v_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;
	logic            out_eoa_q;
	status_t         out_st_q;

	// RAM read data
	logic [38:0]     ofs_rd;	// {namelen, offset}
	logic [63:0]     cs_rd;	// {size, crc}
	logic [7:0]      nm_rd;

	logic            slot_free, emit, job_last, job_done, acc;
	logic [7:0]      jb;
	logic            jeoa, rec_end;
	logic [POSW-1:0] rec_len;

	// request decode
	logic            dec_err;
	status_t         dec_st;
	cmd_t            c;
	job_kind_t       acc_kind;
	logic [CW-1:0]   p_ent;
	logic [POSW-1:0] p_pos;
	logic [31:0]     p_dir;
	logic            p_eocd;
	logic [POSW-1:0] p_k;

	assign c = cmd_t'(cmd);
	assign slot_free = !out_v_q || !out_stall;
	assign emit = job_v_q && slot_free;

	always_comb begin
		case (job_kind_q)
			JK_LHDR: job_last = (job_idx_q == LHDR_LAST);
			JK_DESC: job_last = (job_idx_q == DESC_LAST);
			default: job_last = 1'b1;
		endcase
	end

	assign job_done = emit && job_last;
	// a pull's trailer update lands in the job stage, so hold off the next request
	assign in_stall = job_v_q && !(job_done && job_kind_q != JK_PULL);
	assign acc = in_valid && !in_stall;

	// pull addressing, based on state as it would be after the first-pull latch
	always_comb begin
		p_ent  = (phase_q == PH_IDLE) ? '0 : trail_entry_q;
		p_pos  = (phase_q == PH_IDLE) ? '0 : trail_pos_q;
		p_dir  = (phase_q == PH_IDLE) ? bytes_written_q : dir_offset_q;
		p_eocd = !(p_ent < entry_count_q);
		p_k    = p_pos - CEN_FIXED;
	end

	always_comb begin
		dec_err = 1'b1;
		dec_st  = ST_ORDER;
		if (phase_q == PH_DONE) begin
			dec_st = ST_DONE;
		end else begin
			case (c)
				CMD_BEGIN: begin
					if (phase_q != PH_IDLE) dec_st = ST_ORDER;
					else if (entry_count_q >= MAX_ENT_C) dec_st = ST_FULL;
					else if (name_length > MAX_NAME_C) dec_st = ST_NAME;
					else dec_err = 1'b0;
				end
				CMD_NAME: begin
					if (phase_q == PH_DATA) dec_st = ST_NAME;
					else if (phase_q != PH_NAMES || name_rem_q == '0) dec_st = ST_ORDER;
					else dec_err = 1'b0;
				end
				CMD_DATA, CMD_END: begin
					if (phase_q == PH_NAMES) dec_st = ST_NAME;
					else if (phase_q != PH_DATA) dec_st = ST_ORDER;
					else dec_err = 1'b0;
				end
				CMD_PULL: begin
					if (phase_q == PH_IDLE || phase_q == PH_TRAIL) dec_err = 1'b0;
				end
				default: dec_err = 1'b1;
			endcase
		end
	end

	// kind of job a request turns into; errors are single bytes
	always_comb begin
		acc_kind = JK_SINGLE;
		if (!dec_err) begin
			case (c)
				CMD_BEGIN: acc_kind = JK_LHDR;
				CMD_END:   acc_kind = JK_DESC;
				CMD_PULL:  acc_kind = JK_PULL;
				default:   acc_kind = JK_SINGLE;
			endcase
		end
	end

	// memories
	logic          ofs_we, cs_we, nm_we, rd_en;
	logic [NAW-1:0] nm_waddr, nm_raddr;

	assign ofs_we = acc && !dec_err && c == CMD_BEGIN;
	assign cs_we  = acc && !dec_err && c == CMD_END;
	assign nm_we  = acc && !dec_err && c == CMD_NAME;
	assign rd_en  = acc && !dec_err && c == CMD_PULL;
	assign nm_waddr = NAW'(entry_count_q[EW-1:0]) * NAW'(MAX_NAME) + NAW'(name_pos_q);
	assign nm_raddr = NAW'(p_ent[EW-1:0]) * NAW'(MAX_NAME) + NAW'(p_k);

	zsaf_ram #(.WIDTH(39), .DEPTH(MAX_ENTRIES)) u_ofs_ram (
		.clk(clk), .wr_en(ofs_we), .wr_addr(entry_count_q[EW-1:0]),
		.wr_data({name_length, bytes_written_q}),
		.rd_en(rd_en), .rd_addr(p_ent[EW-1:0]), .rd_data(ofs_rd)
	);

	zsaf_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_cs_ram (
		.clk(clk), .wr_en(cs_we), .wr_addr(entry_count_q[EW-1:0]),
		.wr_data({data_count_q, ~crc_q}),
		.rd_en(rd_en), .rd_addr(p_ent[EW-1:0]), .rd_data(cs_rd)
	);

	zsaf_ram #(.WIDTH(8), .DEPTH(ND)) u_name_ram (
		.clk(clk), .wr_en(nm_we), .wr_addr(nm_waddr), .wr_data(in_byte),
		.rd_en(rd_en), .rd_addr(nm_raddr), .rd_data(nm_rd)
	);

	// byte generation for the job at the head
	always_comb begin
		jb = 8'd0;
		jeoa = 1'b0;
		rec_len = job_eocd_q ? EOCD_LEN : (CEN_FIXED + POSW'(ofs_rd[38:32]));
		rec_end = (job_pos_q + POSW'(1)) >= rec_len;
		case (job_kind_q)
			JK_SINGLE: jb = job_byte_q;
			JK_LHDR: begin
				case (job_idx_q)
					5'd0, 5'd1, 5'd2, 5'd3: jb = byte_of(SIG_LOCAL, job_idx_q[1:0]);
					5'd4: jb = VERSION[7:0];
					5'd5: jb = VERSION[15:8];
					5'd6: jb = GP_FLAG[7:0];
					5'd7: jb = GP_FLAG[15:8];
					5'd26: jb = {1'b0, job_nl_q};
					default: jb = 8'd0;
				endcase
			end
			JK_DESC: begin
				case (job_idx_q[3:2])
					2'd0: jb = byte_of(SIG_DESC, job_idx_q[1:0]);
					2'd1: jb = byte_of(job_crc_q, job_idx_q[1:0]);
					default: jb = byte_of(job_size_q, job_idx_q[1:0]);
				endcase
			end
			default: begin
				if (job_eocd_q) begin
					jeoa = rec_end;
					case (job_pos_q)
						8'd0, 8'd1, 8'd2, 8'd3: jb = byte_of(SIG_EOCD, job_pos_q[1:0]);
						8'd8, 8'd10: jb = byte_of(32'(job_cnt_q), 2'd0);
						8'd9, 8'd11: jb = byte_of(32'(job_cnt_q), 2'd1);
						8'd12, 8'd13, 8'd14, 8'd15: jb = byte_of(job_size_q, job_pos_q[1:0]);
						8'd16, 8'd17, 8'd18, 8'd19: jb = byte_of(job_dir_q, job_pos_q[1:0]);
						default: jb = 8'd0;
					endcase
				end else if (job_pos_q >= CEN_FIXED) begin
					jb = nm_rd;
				end else begin
					case (job_pos_q)
						8'd0, 8'd1, 8'd2, 8'd3: jb = byte_of(SIG_CENTRAL, job_pos_q[1:0]);
						8'd4, 8'd6: jb = VERSION[7:0];
						8'd5, 8'd7: jb = VERSION[15:8];
						8'd8: jb = GP_FLAG[7:0];
						8'd9: jb = GP_FLAG[15:8];
						8'd16, 8'd17, 8'd18, 8'd19: jb = byte_of(cs_rd[31:0], job_pos_q[1:0]);
						8'd20, 8'd21, 8'd22, 8'd23,
						8'd24, 8'd25, 8'd26, 8'd27: jb = byte_of(cs_rd[63:32], job_pos_q[1:0]);
						8'd28: jb = {1'b0, ofs_rd[38:32]};
						// local header offset starts at byte 42, not word aligned
						8'd42: jb = byte_of(ofs_rd[31:0], 2'd0);
						8'd43: jb = byte_of(ofs_rd[31:0], 2'd1);
						8'd44: jb = byte_of(ofs_rd[31:0], 2'd2);
						8'd45: jb = byte_of(ofs_rd[31:0], 2'd3);
						default: jb = 8'd0;
					endcase
				end
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			entry_count_q   <= '0;
			crc_q           <= '0;
			data_count_q    <= '0;
			bytes_written_q <= '0;
			dir_offset_q    <= '0;
			name_rem_q      <= '0;
			name_pos_q      <= '0;
			trail_entry_q   <= '0;
			trail_pos_q     <= '0;
			job_v_q         <= 1'b0;
			out_v_q         <= 1'b0;
		end else begin
			if (slot_free) begin
				out_v_q <= emit;
			end
			if (emit && !job_last) begin
				job_idx_q <= job_idx_q + 5'd1;
			end
			if (job_done && !acc) begin
				job_v_q <= 1'b0;
			end
			// pull: advance trailer position once read data is in
			if (emit && job_kind_q == JK_PULL) begin
				if (rec_end) begin
					trail_pos_q <= '0;
					if (job_eocd_q) phase_q <= PH_DONE;
					else trail_entry_q <= trail_entry_q + CW'(1);
				end else begin
					trail_pos_q <= trail_pos_q + POSW'(1);
				end
			end
			if (acc) begin
				job_v_q    <= 1'b1;
				job_idx_q  <= '0;
				job_kind_q <= acc_kind;
				job_byte_q <= (!dec_err && (c == CMD_NAME || c == CMD_DATA)) ? in_byte : 8'd0;
				job_st_q   <= dec_err ? dec_st : ST_OK;
				if (!dec_err) begin
					case (c)
						CMD_BEGIN: begin
							job_nl_q        <= name_length;
							bytes_written_q <= bytes_written_q + 32'd30;
							crc_q           <= '1;
							data_count_q    <= '0;
							name_rem_q      <= name_length;
							name_pos_q      <= '0;
							phase_q         <= (name_length != '0) ? PH_NAMES : PH_DATA;
						end
						CMD_NAME: begin
							name_rem_q      <= name_rem_q - 7'd1;
							name_pos_q      <= name_pos_q + 7'd1;
							bytes_written_q <= bytes_written_q + 32'd1;
							if (name_rem_q == 7'd1) phase_q <= PH_DATA;
						end
						CMD_DATA: begin
							crc_q           <= crc_byte(crc_q, in_byte);
							data_count_q    <= data_count_q + 32'd1;
							bytes_written_q <= bytes_written_q + 32'd1;
						end
						CMD_END: begin
							job_crc_q       <= ~crc_q;
							job_size_q      <= data_count_q;
							crc_q           <= ~crc_q;
							entry_count_q   <= entry_count_q + CW'(1);
							bytes_written_q <= bytes_written_q + 32'd16;
							phase_q         <= PH_IDLE;
						end
						default: begin
							job_pos_q       <= p_pos;
							job_eocd_q      <= p_eocd;
							job_cnt_q       <= entry_count_q;
							job_dir_q       <= p_dir;
							job_size_q      <= bytes_written_q - 32'(p_pos) - p_dir;
							bytes_written_q <= bytes_written_q + 32'd1;
							if (phase_q == PH_IDLE) begin
								dir_offset_q  <= bytes_written_q;
								trail_entry_q <= '0;
								trail_pos_q   <= '0;
								phase_q       <= PH_TRAIL;
							end
						end
					endcase
				end
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= jb;
			out_last_q <= job_last;
			out_eoa_q  <= jeoa;
			out_st_q   <= job_st_q;
		end
	end

	assign out_valid      = out_v_q;
	assign out_byte       = out_byte_q;
	assign last           = out_last_q;
	assign end_of_archive = out_eoa_q;
	assign status         = out_st_q;
endmodule
